// ===== src/explicit_free_list_allocator_defines.svh =====
// Assertion macros for the free-list allocator
`ifndef EXPLICIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define EXPLICIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
// assert that a property holds on every clock edge outside reset
`define EFLA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assert a property that is checked during reset as well
`define EFLA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/efla_pkg.sv =====
// Package: types and constants for the free-list allocator
package efla_pkg;
   localparam int unsigned OpAlloc = 0;
   localparam int unsigned OpFree  = 1;

   typedef enum logic [4:0] {
      ST_RESET, ST_IDLE,
      ST_A_RD, ST_A_WAIT, ST_A_CHK,
      ST_A_SPL0, ST_A_SPL1, ST_A_SPL2,
      ST_A_CUR, ST_U_RD, ST_U_WAIT, ST_U_P, ST_U_N,
      ST_F_MARK, ST_F_HPREV,
      ST_M_RDC, ST_M_WAITC, ST_M_RDN, ST_M_WAITN, ST_M_CHK, ST_M_GROW,
      ST_RESP
   } efla_state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_INIT, CMD_LOAD, CMD_RD_CUR, CMD_RD_NB,
      CMD_ADV, CMD_SPLIT0, CMD_SPLIT2, CMD_HPREV,
      CMD_USE, CMD_UNL_P, CMD_UNL_N, CMD_FMARK, CMD_GROW, CMD_STEP
   } efla_cmd_type;

   typedef struct packed {
      logic alloc_op;
      logic is_null;
      logic bad_free;
      logic fits;
      logic do_split;
      logic at_end;
      logic both_free;
      logic walk_end;
      logic nb_ok;
   } efla_status_type;
endpackage

// ===== src/efla_if.sv =====
// Interface: valid/ready channel carrying one item
interface efla_if #(parameter int unsigned W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/efla_ctrl.sv =====
// Controller: sequences allocation, free and merge walks
module efla_ctrl import efla_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  efla_status_type stat,
   output efla_cmd_type    cmd,
   output logic            set_grant,
   output logic            clr_grant
);
   efla_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_RESET;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      set_grant = 1'b0;
      clr_grant = 1'b0;
      case (state_ff)
         ST_RESET: begin
            cmd = CMD_INIT;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd = CMD_LOAD;
               state_in = ST_A_RD;
            end
         end
         ST_A_RD: begin
            clr_grant = 1'b1;
            if (stat.alloc_op) begin
               if (stat.walk_end) state_in = ST_RESP;
               else begin
                  cmd = CMD_RD_CUR;
                  state_in = ST_A_WAIT;
               end
            end else if (stat.is_null) begin
               set_grant = 1'b1;
               state_in = ST_RESP;
            end else if (stat.bad_free) state_in = ST_RESP;
            else begin
               cmd = CMD_RD_CUR;
               state_in = ST_F_MARK;
            end
         end
         ST_A_WAIT: state_in = ST_A_CHK;
         ST_A_CHK: begin
            if (stat.fits) begin
               if (stat.do_split && stat.nb_ok) state_in = ST_A_SPL0;
               else if (stat.do_split) state_in = ST_A_SPL2;
               else state_in = ST_A_CUR;
            end else begin
               cmd = CMD_ADV;
               state_in = ST_A_RD;
            end
         end
         ST_A_SPL0: begin cmd = CMD_SPLIT0; state_in = ST_A_SPL1; end
         ST_A_SPL1: begin cmd = CMD_HPREV; state_in = ST_A_SPL2; end
         ST_A_SPL2: begin cmd = CMD_SPLIT2; state_in = ST_A_CUR; end
         ST_A_CUR: begin
            cmd = CMD_USE;
            set_grant = 1'b1;
            state_in = ST_U_RD;
         end
         ST_U_RD: begin cmd = CMD_RD_CUR; state_in = ST_U_WAIT; end
         ST_U_WAIT: state_in = ST_U_P;
         ST_U_P: begin cmd = CMD_UNL_P; state_in = ST_U_N; end
         ST_U_N: begin
            cmd = CMD_UNL_N;
            state_in = stat.alloc_op ? ST_RESP : ST_M_GROW;
         end
         ST_F_MARK: begin
            cmd = CMD_FMARK;
            set_grant = 1'b1;
            state_in = ST_F_HPREV;
         end
         ST_F_HPREV: begin cmd = CMD_HPREV; state_in = ST_M_RDC; end
         ST_M_RDC: begin cmd = CMD_RD_CUR; state_in = ST_M_WAITC; end
         ST_M_WAITC: state_in = ST_M_RDN;
         ST_M_RDN: begin
            if (stat.at_end) state_in = ST_RESP;
            else begin
               cmd = CMD_RD_NB;
               state_in = ST_M_WAITN;
            end
         end
         ST_M_WAITN: state_in = ST_M_CHK;
         ST_M_CHK: begin
            if (stat.both_free) begin
               cmd = CMD_GROW;
               state_in = ST_U_RD;
            end else begin
               cmd = CMD_STEP;
               state_in = ST_M_RDC;
            end
         end
         ST_M_GROW: state_in = ST_M_RDC;
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_RESET;
      endcase
   end
endmodule

// ===== src/efla_dp.sv =====
// Datapath: block stores, walk pointers and size arithmetic
module efla_dp import efla_pkg::*; #(
   parameter int unsigned POOL_BYTES   = 10240,
   parameter int unsigned HEADER_BYTES = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  efla_cmd_type    cmd,
   input  logic            set_grant,
   input  logic            clr_grant,
   input  logic            in_op,
   input  logic [13:0]     in_req,
   input  logic [13:0]     in_off,
   input  logic            in_null,
   output efla_status_type stat,
   output logic            out_granted,
   output logic [13:0]     out_offset
);
   localparam int unsigned Depth = POOL_BYTES / 4;
   localparam int unsigned IW    = $clog2(Depth + 1);
   localparam int unsigned AW    = $clog2(Depth);
   localparam int unsigned SW    = $clog2(POOL_BYTES + 1);
   localparam int unsigned BW    = SW + 2;
   localparam logic [IW-1:0] Nil = IW'(Depth);
   localparam logic [BW-1:0] Hdr = BW'(HEADER_BYTES);
   localparam logic [BW-1:0] Pool = BW'(POOL_BYTES);

   logic [SW-1:0] size_mem [Depth];
   logic          free_mem [Depth];
   logic [IW-1:0] next_mem [Depth];
   logic [IW-1:0] prev_mem [Depth];

   logic          op_ff, null_ff, grant_ff;
   logic [13:0]   off_ff, out_off_ff;
   logic [BW-1:0] want_ff;
   logic [IW-1:0] head_ff, cur_ff, tgt_ff, nbi_ff, ohead_ff;
   logic [IW-1:0] steps_ff;
   logic [BW-1:0] mcur_ff;
   logic [SW-1:0] rd_size_ff, nb_size_ff;
   logic          rd_free_ff, nb_free_ff;
   logic [IW-1:0] rd_next_ff, rd_prev_ff;

   logic          wr_en;
   logic [AW-1:0] wr_a;
   logic          wr_size, wr_free, wr_next, wr_prev;
   logic [SW-1:0] wd_size;
   logic          wd_free;
   logic [IW-1:0] wd_next, wd_prev;
   logic          rd_en;
   logic [AW-1:0] rd_a;
   logic          rd_nb;

   function automatic logic okb(input logic [IW-1:0] b);
      return b < Nil;
   endfunction

   function automatic logic [SW-1:0] sat(input logic [BW-1:0] v);
      return (v > Pool) ? SW'(POOL_BYTES) : v[SW-1:0];
   endfunction

   logic [BW-1:0] split_b, new_sz, merge_sz, nxt_b, fbyte;
   logic [BW-1:0] cur_b;
   logic [IW-1:0] split_i, free_i;

   assign cur_b    = BW'(cur_ff) << 2;
   assign split_b  = cur_b + Hdr + want_ff;
   assign split_i  = IW'(split_b >> 2);
   assign new_sz   = BW'(rd_size_ff) - want_ff - Hdr;
   assign merge_sz = BW'(rd_size_ff) + Hdr + BW'(nb_size_ff);
   assign nxt_b    = mcur_ff + Hdr + BW'(rd_size_ff);
   assign fbyte    = BW'(off_ff) - Hdr;
   assign free_i   = IW'(fbyte >> 2);

   always_comb begin
      stat.alloc_op  = (op_ff == 1'(OpAlloc));
      stat.is_null   = null_ff;
      stat.bad_free  = (BW'(off_ff) < Hdr) || (fbyte[1:0] != 2'd0) ||
                       (BW'(off_ff) >= Pool + Hdr);
      stat.fits      = rd_free_ff && (BW'(rd_size_ff) >= want_ff);
      stat.do_split  = BW'(rd_size_ff) > want_ff + Hdr + BW'(4);
      stat.nb_ok     = split_b < Pool;
      stat.at_end    = nxt_b >= Pool;
      stat.both_free = rd_free_ff && nb_free_ff;
      stat.walk_end  = !okb(cur_ff) || (steps_ff >= Nil);
   end

   always_comb begin
      wr_en = 1'b0; wr_a = '0;
      wr_size = 1'b0; wr_free = 1'b0; wr_next = 1'b0; wr_prev = 1'b0;
      wd_size = '0; wd_free = 1'b0; wd_next = Nil; wd_prev = Nil;
      rd_en = 1'b0; rd_a = '0; rd_nb = 1'b0;
      case (cmd)
         CMD_INIT: begin
            wr_en = 1'b1; wr_size = 1'b1; wr_free = 1'b1; wr_next = 1'b1;
            wr_prev = 1'b1; wd_size = SW'(POOL_BYTES - HEADER_BYTES);
            wd_free = 1'b1;
         end
         CMD_RD_CUR: begin
            rd_en = okb(tgt_ff); rd_a = tgt_ff[AW-1:0];
         end
         CMD_RD_NB: begin
            rd_en = 1'b1; rd_nb = 1'b1; rd_a = AW'(nxt_b >> 2);
         end
         CMD_SPLIT0: begin
            wr_en = okb(split_i); wr_a = split_i[AW-1:0];
            wr_size = 1'b1; wr_free = 1'b1; wr_next = 1'b1; wr_prev = 1'b1;
            wd_size = sat(new_sz); wd_free = 1'b1; wd_next = head_ff;
         end
         CMD_SPLIT2: begin
            wr_en = okb(cur_ff); wr_a = cur_ff[AW-1:0];
            wr_size = 1'b1; wd_size = sat(want_ff);
         end
         CMD_HPREV: begin
            // previous head gets the pushed block as its predecessor
            wr_en = okb(ohead_ff) && (ohead_ff != nbi_ff);
            wr_a = ohead_ff[AW-1:0]; wr_prev = 1'b1; wd_prev = nbi_ff;
         end
         CMD_USE: begin
            wr_en = okb(cur_ff); wr_a = cur_ff[AW-1:0];
            wr_free = 1'b1; wd_free = 1'b0;
         end
         CMD_UNL_P: begin
            wr_en = okb(rd_prev_ff); wr_a = rd_prev_ff[AW-1:0];
            wr_next = 1'b1; wd_next = rd_next_ff;
         end
         CMD_UNL_N: begin
            wr_en = okb(rd_next_ff); wr_a = rd_next_ff[AW-1:0];
            wr_prev = 1'b1; wd_prev = rd_prev_ff;
         end
         CMD_FMARK: begin
            wr_en = 1'b1; wr_a = free_i[AW-1:0];
            wr_free = 1'b1; wr_next = 1'b1; wr_prev = 1'b1;
            wd_free = 1'b1; wd_next = head_ff;
         end
         CMD_GROW: begin
            wr_en = 1'b1; wr_a = AW'(mcur_ff >> 2);
            wr_size = 1'b1; wd_size = sat(merge_sz);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_size) size_mem[wr_a] <= wd_size;
         if (wr_free) free_mem[wr_a] <= wd_free;
         if (wr_next) next_mem[wr_a] <= wd_next;
         if (wr_prev) prev_mem[wr_a] <= wd_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_nb) begin
            nb_size_ff <= size_mem[rd_a];
            nb_free_ff <= free_mem[rd_a];
         end else begin
            rd_size_ff <= size_mem[rd_a];
            rd_free_ff <= free_mem[rd_a];
         end
         rd_next_ff <= next_mem[rd_a];
         rd_prev_ff <= prev_mem[rd_a];
      end else if (cmd == CMD_RD_CUR) begin
         rd_size_ff <= '0; rd_free_ff <= 1'b0;
         rd_next_ff <= Nil; rd_prev_ff <= Nil;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         grant_ff <= 1'b0;
      end else begin
         if (set_grant) grant_ff <= 1'b1;
         else if (clr_grant) grant_ff <= 1'b0;
         case (cmd)
            CMD_SPLIT0: if (okb(split_i)) head_ff <= split_i;
            CMD_FMARK: head_ff <= free_i;
            CMD_UNL_N: if (tgt_ff == head_ff) head_ff <= rd_next_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            op_ff <= in_op; null_ff <= in_null; off_ff <= in_off;
            want_ff <= (BW'(in_req) + BW'(3)) & ~BW'(3);
            cur_ff <= head_ff; tgt_ff <= head_ff; steps_ff <= '0;
            out_off_ff <= '0;
         end
         CMD_ADV: begin
            cur_ff <= rd_next_ff; tgt_ff <= rd_next_ff;
            steps_ff <= steps_ff + IW'(1);
         end
         CMD_SPLIT0: begin
            nbi_ff <= split_i; ohead_ff <= head_ff;
         end
         CMD_USE: out_off_ff <= 14'(cur_b + Hdr);
         CMD_FMARK: begin
            nbi_ff <= free_i; ohead_ff <= head_ff; mcur_ff <= '0; tgt_ff <= '0;
         end
         CMD_GROW: tgt_ff <= IW'(nxt_b >> 2);
         CMD_UNL_N: tgt_ff <= IW'(mcur_ff >> 2);
         CMD_STEP: begin
            mcur_ff <= nxt_b; tgt_ff <= IW'(nxt_b >> 2);
         end
         default: ;
      endcase
   end

   assign out_granted = grant_ff;
   assign out_offset  = grant_ff ? out_off_ff : '0;
endmodule

// ===== src/explicit_free_list_allocator.sv =====
// Explicit free-list first-fit allocator, sequential controller and datapath.
// Throughput: one item at a time; the next is taken the cycle after the response leaves.
// Reset: synchronous; the reset state writes the initial whole-pool block, then idle.
`include "explicit_free_list_allocator_defines.svh"
module explicit_free_list_allocator import efla_pkg::*; #(
   parameter int unsigned POOL_BYTES   = 10240,
   parameter int unsigned HEADER_BYTES = 32
) (
   input logic clock,
   input logic reset,
   efla_if.sink   req,
   efla_if.source rsp
);
   efla_status_type stat;
   efla_cmd_type    cmd;
   logic            set_grant, clr_grant, granted;
   logic [13:0]     offset;

   efla_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .stat, .cmd, .set_grant, .clr_grant
   );

   efla_dp #(.POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_dp (
      .clock, .reset, .cmd, .set_grant, .clr_grant,
      .in_op (req.data[0]), .in_req (req.data[14:1]),
      .in_off (req.data[28:15]), .in_null (req.data[29]),
      .stat, .out_granted (granted), .out_offset (offset)
   );

   assign rsp.data = {offset, granted};

   `EFLA_ASSERT(a_no_overlap, clock, reset, !(req.ready && rsp.valid), "busy overlap")
   `EFLA_ASSERT(a_fail_zero, clock, reset, (rsp.valid && !rsp.data[0]) |-> (rsp.data[14:1] == 14'd0), "failed item carries offset")
   `EFLA_ASSERT(a_rsp_hold, clock, reset, (rsp.valid && !rsp.ready) |=> rsp.valid, "item dropped")
endmodule
